>>> rtl/vchl_pkg.sv
`default_nettype none
package vchl_pkg;

    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_UPPER = 2'd1;
    localparam logic [1:0] OP_LOWER = 2'd2;

    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;
    localparam logic [1:0] REG_BASE   = 2'd3;

    // numerator / divisor width of the cell mapping, limit sum width
    localparam int NUM_W = 42;
    localparam int LIM_W = 40;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  cell_x;
        logic [3:0]  cell_y;
        logic [3:0]  cell_z;
        logic        occupied;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic        set_ok;
    } vchl_cmd_t;

    typedef struct packed {
        logic clearing;
    } vchl_status_t;

endpackage
`default_nettype wire

>>> rtl/vchl_front.sv
`default_nettype none
module vchl_front
    import vchl_pkg::*;
#(
    parameter int GRID_WIDTH  = 16,
    parameter int GRID_HEIGHT = 16,
    parameter int GRID_DEPTH  = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [1:0]   op,
    input  wire logic [3:0]   cell_x,
    input  wire logic [3:0]   cell_y,
    input  wire logic [3:0]   cell_z,
    input  wire logic         occupied,
    input  wire logic [31:0]  pos_x,
    input  wire logic [31:0]  pos_y,
    input  wire logic [31:0]  pos_z,
    input  wire vchl_status_t status,
    output logic              push_valid,
    input  wire logic         push_ready,
    output vchl_cmd_t         push_cmd
);

    logic      hold_valid_reg;
    vchl_cmd_t cmd_reg;
    vchl_cmd_t cmd_next;

    assign in_ready   = !status.clearing && (!hold_valid_reg || push_ready);
    assign push_valid = hold_valid_reg;
    assign push_cmd   = cmd_reg;

    always_comb
    begin
        cmd_next.op       = op;
        cmd_next.cell_x   = cell_x;
        cmd_next.cell_y   = cell_y;
        cmd_next.cell_z   = cell_z;
        cmd_next.occupied = occupied;
        cmd_next.pos_x    = pos_x;
        cmd_next.pos_y    = pos_y;
        cmd_next.pos_z    = pos_z;
        cmd_next.set_ok   = (32'(cell_x) < GRID_WIDTH) && (32'(cell_y) < GRID_HEIGHT)
                            && (32'(cell_z) < GRID_DEPTH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/vchl_queue.sv
`default_nettype none
module vchl_queue
    import vchl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_valid,
    output logic           push_ready,
    input  wire vchl_cmd_t push_cmd,
    output logic           pop_valid,
    input  wire logic      pop_ready,
    output vchl_cmd_t      pop_cmd
);

    vchl_cmd_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

>>> rtl/vchl_back.sv
`default_nettype none
module vchl_back
    import vchl_pkg::*;
#(
    parameter int GRID_WIDTH  = 16,
    parameter int GRID_HEIGHT = 16,
    parameter int GRID_DEPTH  = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         pop_valid,
    output logic              pop_ready,
    input  wire vchl_cmd_t    pop_cmd,
    input  wire logic [30:0]  box_size_x,
    input  wire logic [30:0]  box_size_y,
    input  wire logic [30:0]  box_size_z,
    input  wire logic [31:0]  base_height,
    output vchl_status_t      status,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [31:0]       limit,
    output logic              found,
    output logic              in_land
);

    localparam int CELLS  = GRID_WIDTH * GRID_DEPTH;
    localparam int AW     = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int KW     = $clog2(GRID_HEIGHT);
    localparam int MAXWD  = (GRID_WIDTH > GRID_DEPTH) ? GRID_WIDTH : GRID_DEPTH;
    localparam int MAXDIM = (MAXWD > GRID_HEIGHT) ? MAXWD : GRID_HEIGHT;
    localparam int QW     = $clog2(MAXDIM + 1);
    localparam int SW     = (QW > 1) ? $clog2(QW) : 1;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_CMP  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_RD   = 4'd5;
    localparam logic [3:0] S_SCAN = 4'd6;
    localparam logic [3:0] S_WR   = 4'd7;
    localparam logic [3:0] S_LMUL = 4'd8;
    localparam logic [3:0] S_LADD = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [GRID_HEIGHT-1:0] column_mem [CELLS];
    logic [GRID_HEIGHT-1:0] rdata_reg;

    logic [3:0]       state_reg;
    vchl_cmd_t        cmd_reg;
    logic [AW-1:0]    clr_reg;
    logic [AW-1:0]    addr_reg;
    logic [1:0]       axis_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] den_reg;
    logic [NUM_W-1:0] prod_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] dsh_reg;
    logic [QW-1:0]    q_reg;
    logic [SW-1:0]    step_reg;
    logic [QW-1:0]    gx_reg;
    logic [QW-1:0]    gy_reg;
    logic [KW-1:0]    k_reg;
    logic             hit_reg;
    logic             inside_reg;
    logic [LIM_W-1:0] lprod_reg;
    logic [31:0]      res_limit_reg;
    logic             out_valid_reg;
    logic [31:0]      limit_reg;
    logic             found_reg;
    logic             in_land_reg;

    logic [NUM_W-1:0] num_ax;
    logic [NUM_W-1:0] den_ax;
    logic [NUM_W-1:0] lim_ax;
    logic             rem_ge;
    logic [QW-1:0]    q_next;
    logic [KW:0]      kk;
    logic [LIM_W-1:0] lsum;
    logic [31:0]      lsat;
    logic             sizes_ok;
    logic             is_upper;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [GRID_HEIGHT-1:0] wr_data;
    logic [GRID_HEIGHT-1:0] bit_mask;
    logic             out_load;

    assign pop_ready       = (state_reg == S_IDLE);
    assign status.clearing = (state_reg == S_CLR);
    assign out_valid       = out_valid_reg;
    assign limit           = limit_reg;
    assign found           = found_reg;
    assign in_land         = in_land_reg;
    assign sizes_ok        = (box_size_x != '0) && (box_size_y != '0) && (box_size_z != '0);
    assign is_upper        = (cmd_reg.op == OP_UPPER);
    assign out_load        = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // numerator, divisor and cell count of the axis under mapping
    always_comb
    begin
        case (axis_reg)
            2'd0:
            begin
                num_ax = {{(NUM_W-33){cmd_reg.pos_x[31]}}, cmd_reg.pos_x, 1'b0}
                         + NUM_W'(box_size_x) * NUM_W'(GRID_WIDTH);
                den_ax = NUM_W'({box_size_x, 1'b0});
                lim_ax = NUM_W'(GRID_WIDTH);
            end
            2'd1:
            begin
                num_ax = {{(NUM_W-32){cmd_reg.pos_y[31]}}, cmd_reg.pos_y}
                         - {{(NUM_W-32){base_height[31]}}, base_height};
                den_ax = NUM_W'(box_size_y);
                lim_ax = NUM_W'(GRID_HEIGHT);
            end
            default:
            begin
                num_ax = {{(NUM_W-33){cmd_reg.pos_z[31]}}, cmd_reg.pos_z, 1'b0}
                         + NUM_W'(box_size_z) * NUM_W'(GRID_DEPTH);
                den_ax = NUM_W'({box_size_z, 1'b0});
                lim_ax = NUM_W'(GRID_DEPTH);
            end
        endcase
    end

    assign rem_ge = (rem_reg >= dsh_reg);
    assign q_next = {q_reg[QW-2:0], rem_ge};

    always_comb
    begin
        if (hit_reg)
        begin
            kk = {1'b0, k_reg};
        end
        else if (is_upper)
        begin
            kk = (KW+1)'(GRID_HEIGHT);
        end
        else
        begin
            kk = '0;
        end
    end

    always_comb
    begin
        if (is_upper)
        begin
            lsum = lprod_reg + {{(LIM_W-32){base_height[31]}}, base_height}
                   - LIM_W'(box_size_y[30:1]);
        end
        else
        begin
            lsum = lprod_reg + {{(LIM_W-32){base_height[31]}}, base_height}
                   + LIM_W'(box_size_y[30:1]);
        end
        // clamp when the bits above 31 are not a plain sign extension
        if (lsum[LIM_W-1:31] == '0 || lsum[LIM_W-1:31] == '1)
        begin
            lsat = lsum[31:0];
        end
        else if (lsum[LIM_W-1])
        begin
            lsat = 32'h8000_0000;
        end
        else
        begin
            lsat = 32'h7fff_ffff;
        end
    end

    assign bit_mask = GRID_HEIGHT'(1) << cmd_reg.cell_y;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = cmd_reg.occupied ? (rdata_reg | bit_mask) : (rdata_reg & ~bit_mask);
        if (state_reg == S_CLR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else if (state_reg == S_WR)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            column_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= column_mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(CELLS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (pop_valid)
                    begin
                        if (pop_cmd.op == OP_SET)
                        begin
                            state_reg <= pop_cmd.set_ok ? S_RD : S_OUT;
                        end
                        else if (pop_cmd.op == OP_UPPER || pop_cmd.op == OP_LOWER)
                        begin
                            state_reg <= sizes_ok ? S_MUL : S_LMUL;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (num_reg[NUM_W-1] || num_reg >= prod_reg)
                    begin
                        state_reg <= S_LMUL;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (step_reg == SW'(QW - 1))
                    begin
                        state_reg <= (axis_reg == 2'd2) ? S_RD : S_MUL;
                    end
                end
                S_RD:
                begin
                    state_reg <= (cmd_reg.op == OP_SET) ? S_WR : S_SCAN;
                end
                S_SCAN:
                begin
                    if (is_upper)
                    begin
                        if (rdata_reg[k_reg] || k_reg == KW'(GRID_HEIGHT - 1))
                        begin
                            state_reg <= S_LMUL;
                        end
                    end
                    else if (k_reg == '0 || rdata_reg[k_reg])
                    begin
                        state_reg <= S_LMUL;
                    end
                end
                S_WR:
                begin
                    state_reg <= S_OUT;
                end
                S_LMUL:
                begin
                    state_reg <= S_LADD;
                end
                S_LADD:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cmd_reg       <= pop_cmd;
                axis_reg      <= 2'd0;
                hit_reg       <= 1'b0;
                inside_reg    <= (pop_cmd.op == OP_SET) && pop_cmd.set_ok;
                res_limit_reg <= '0;
                addr_reg      <= AW'(32'(pop_cmd.cell_x) * GRID_DEPTH + 32'(pop_cmd.cell_z));
            end
            S_MUL:
            begin
                num_reg  <= num_ax;
                den_reg  <= den_ax;
                prod_reg <= lim_ax * den_ax;
            end
            S_CMP:
            begin
                rem_reg  <= num_reg;
                dsh_reg  <= den_reg << (QW - 1);
                q_reg    <= '0;
                step_reg <= '0;
            end
            S_DIV:
            begin
                if (rem_ge)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                dsh_reg  <= dsh_reg >> 1;
                q_reg    <= q_next;
                step_reg <= step_reg + 1'b1;
                if (step_reg == SW'(QW - 1))
                begin
                    axis_reg <= axis_reg + 2'd1;
                    case (axis_reg)
                        2'd0:
                        begin
                            gx_reg <= q_next;
                        end
                        2'd1:
                        begin
                            gy_reg <= q_next;
                        end
                        default:
                        begin
                            inside_reg <= 1'b1;
                            addr_reg   <= AW'(32'(gx_reg) * GRID_DEPTH + 32'(q_next));
                        end
                    endcase
                end
            end
            S_RD:
            begin
                k_reg <= gy_reg[KW-1:0];
            end
            S_SCAN:
            begin
                if (is_upper)
                begin
                    if (rdata_reg[k_reg])
                    begin
                        hit_reg <= 1'b1;
                    end
                    else if (k_reg != KW'(GRID_HEIGHT - 1))
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                else if (k_reg != '0)
                begin
                    if (rdata_reg[k_reg])
                    begin
                        hit_reg <= 1'b1;
                    end
                    else
                    begin
                        k_reg <= k_reg - 1'b1;
                    end
                end
            end
            S_LMUL:
            begin
                lprod_reg <= LIM_W'(kk) * LIM_W'(box_size_y);
            end
            S_LADD:
            begin
                res_limit_reg <= lsat;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            limit_reg   <= res_limit_reg;
            found_reg   <= hit_reg;
            in_land_reg <= inside_reg;
        end
    end

endmodule
`default_nettype wire

>>> rtl/voxel_column_height_limits_unit.sv
`default_nettype none
// Channel    Handshake                      Payload
// input      in_valid / in_ready            op, cell_x..cell_z, occupied, pos_x..pos_z
// output     out_valid / out_ready          limit, found, in_land
// config     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// In the back end a set reads its column and writes it back. A query maps each axis to a
// cell through one shared restoring divider with QW = clog2(max grid dimension + 1)
// quotient bits, then scans the layers of that column and computes the limit.
// After reset the column memory is zeroed, one column a cycle, over all
// GRID_WIDTH*GRID_DEPTH columns; in_ready stays low meanwhile.
// A two-entry queue lets the front keep taking transfers while the back works.
module voxel_column_height_limits_unit
    import vchl_pkg::*;
#(
    parameter int GRID_WIDTH  = 16,
    parameter int GRID_HEIGHT = 16,
    parameter int GRID_DEPTH  = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [1:0]   op,
    input  wire logic [3:0]   cell_x,
    input  wire logic [3:0]   cell_y,
    input  wire logic [3:0]   cell_z,
    input  wire logic         occupied,
    input  wire logic [31:0]  pos_x,
    input  wire logic [31:0]  pos_y,
    input  wire logic [31:0]  pos_z,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [31:0]       limit,
    output logic              found,
    output logic              in_land,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [30:0]  box_size_x_reg;
    logic [30:0]  box_size_y_reg;
    logic [30:0]  box_size_z_reg;
    logic [31:0]  base_height_reg;
    logic         cfg_write;

    vchl_status_t status;
    logic         push_valid;
    logic         push_ready;
    vchl_cmd_t    push_cmd;
    logic         pop_valid;
    logic         pop_ready;
    vchl_cmd_t    pop_cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_size_x_reg  <= 31'd65536;
            box_size_y_reg  <= 31'd65536;
            box_size_z_reg  <= 31'd65536;
            base_height_reg <= 32'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_SIZE_X: box_size_x_reg  <= pwdata[30:0];
                REG_SIZE_Y: box_size_y_reg  <= pwdata[30:0];
                REG_SIZE_Z: box_size_z_reg  <= pwdata[30:0];
                REG_BASE:   base_height_reg <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SIZE_X: prdata = {1'b0, box_size_x_reg};
            REG_SIZE_Y: prdata = {1'b0, box_size_y_reg};
            REG_SIZE_Z: prdata = {1'b0, box_size_z_reg};
            REG_BASE:   prdata = base_height_reg;
            default:    prdata = '0;
        endcase
    end

    vchl_front #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .GRID_DEPTH  (GRID_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_z     (cell_z),
        .occupied   (occupied),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .status     (status),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    vchl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    vchl_back #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .GRID_DEPTH  (GRID_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_cmd     (pop_cmd),
        .box_size_x  (box_size_x_reg),
        .box_size_y  (box_size_y_reg),
        .box_size_z  (box_size_z_reg),
        .base_height (base_height_reg),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .limit       (limit),
        .found       (found),
        .in_land     (in_land)
    );

endmodule
`default_nettype wire
